>>> rtl/palette_grid_upscaler_unit_assert.svh
// Assertion macros shared by the palette grid upscaler RTL.
`ifndef PALETTE_GRID_UPSCALER_UNIT_ASSERT_SVH
`define PALETTE_GRID_UPSCALER_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PGU_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pgu assertion failed");

// Consequent checked in the cycle after the antecedent.
`define PGU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pgu assertion failed");

`endif

>>> rtl/pgu_pkg.sv
// Shared types, constants and palette lookup for the palette grid upscaler.
package pgu_pkg;

   localparam int unsigned REQ_DATA_W  = 40;
   localparam int unsigned RSP_DATA_W  = 56;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [16:0] W_ONE  = 17'h10000;
   localparam logic [36:0] P_HALF = 37'h8000;
   localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SMOOTH  = 3'd0,
      CSR_OVERLAY = 3'd1,
      CSR_X_STEP  = 3'd2,
      CSR_Y_STEP  = 3'd3,
      CSR_BG      = 3'd4
   } csr_index_type;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_RENDER = 1'b1
   } op_type;

   localparam logic [31:0] PAL_FIXED [16] = '{
      32'h00000000, 32'hFFFF5000, 32'hFF9F1FFF, 32'hFFDF0000,
      32'hFF2AD625, 32'hFF00DFCF, 32'hFFDF00FF, 32'hFFE7EE00,
      32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
      32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
   };

   function automatic logic [31:0] palette_color(input logic [3:0] owner,
                                                 input logic [31:0] bg,
                                                 input logic [3:0] owner_count);
      logic [31:0] c;
      c = PAL_FIXED[owner];
      if (owner == 4'd0) begin
         c = bg;
      end else if (owner > owner_count) begin
         c = 32'h0;
      end
      return c;
   endfunction

endpackage

>>> rtl/pgu_grid_ram.sv
// Owner grid split into four parity banks, with a clearing pass after reset.
module pgu_grid_ram #(
   parameter int GRID_DIM = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic [$clog2(GRID_DIM)-1:0] rd_x,
   input  logic [$clog2(GRID_DIM)-1:0] rd_y,
   input  logic                        wr_en,
   input  logic [$clog2(GRID_DIM)-1:0] wr_x,
   input  logic [$clog2(GRID_DIM)-1:0] wr_y,
   input  logic [3:0]                  wr_owner,
   output logic                        busy,
   output logic [3:0]                  q00,
   output logic [3:0]                  q01,
   output logic [3:0]                  q10,
   output logic [3:0]                  q11
);
   localparam int CW    = $clog2(GRID_DIM);
   localparam int HALF  = (GRID_DIM + 1) / 2;
   localparam int DEPTH = HALF * HALF;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [CW-1:0] LAST = CW'(GRID_DIM - 1);
   localparam logic [AW-1:0] HALF_A = AW'(HALF);
   localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

   logic          busy_ff, busy_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic          par_x_ff, par_y_ff;
   logic [3:0]    q_ff [4];
   logic [CW-1:0] x1, y1;
   logic [AW-1:0] rd_addr [4];
   logic [AW-1:0] wr_addr;
   logic [1:0]    wr_bank;

   always_comb begin
      busy_in    = busy_ff;
      clr_cnt_in = clr_cnt_ff;
      if (busy_ff) begin
         clr_cnt_in = clr_cnt_ff + AW'(1);
         if (clr_cnt_ff == CLR_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   assign busy = busy_ff;

   // neighbor column and row, held at the last one
   assign x1 = (rd_x == LAST) ? rd_x : rd_x + CW'(1);
   assign y1 = (rd_y == LAST) ? rd_y : rd_y + CW'(1);

   assign wr_bank = {wr_y[0], wr_x[0]};
   assign wr_addr = AW'(wr_y[CW-1:1]) * HALF_A + AW'(wr_x[CW-1:1]);

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [3:0]    mem [DEPTH];
      logic [CW-1:0] sel_x, sel_y;

      assign sel_x = (rd_x[0] == 1'(b % 2)) ? rd_x : x1;
      assign sel_y = (rd_y[0] == 1'(b / 2)) ? rd_y : y1;
      assign rd_addr[b] = AW'(sel_y[CW-1:1]) * HALF_A + AW'(sel_x[CW-1:1]);

      always_ff @(posedge clock) begin
         if (busy_ff) begin
            mem[clr_cnt_ff] <= 4'd0;
         end else if (wr_en && (wr_bank == 2'(b))) begin
            mem[wr_addr] <= wr_owner;
         end
         if (en) begin
            q_ff[b] <= mem[rd_addr[b]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         par_x_ff <= rd_x[0];
         par_y_ff <= rd_y[0];
      end
   end

   assign q00 = q_ff[{par_y_ff, par_x_ff}];
   assign q01 = q_ff[{par_y_ff, ~par_x_ff}];
   assign q10 = q_ff[{~par_y_ff, par_x_ff}];
   assign q11 = q_ff[{~par_y_ff, ~par_x_ff}];

endmodule

>>> rtl/pgu_smoother.sv
// Three-stage smootherstep weight in Q1.16: t^2, then t^3 and q, then product.
module pgu_smoother (
   input  logic        clock,
   input  logic        en,
   input  logic [16:0] t_in,
   output logic [16:0] s_out
);
   import pgu_pkg::*;

   logic [32:0] tt_ff, tt_in;
   logic [16:0] t_ff;
   logic [48:0] t3_ff, t3_in;
   logic [19:0] qh_ff;
   logic [36:0] q_in;
   logic [52:0] prod_in;
   logic [20:0] raw_ff;

   assign tt_in   = 33'(t_in) * 33'(t_in);
   assign t3_in   = 49'(tt_ff) * 49'(t_ff);
   assign q_in    = 37'(tt_ff) * 37'd6 + 37'h0A00000000 - ((37'(t_ff) * 37'd15) << 16);
   assign prod_in = 53'(t3_ff[48:16]) * 53'(qh_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         tt_ff  <= tt_in;
         t_ff   <= t_in;
         t3_ff  <= t3_in;
         qh_ff  <= q_in[35:16];
         raw_ff <= prod_in[52:32];
      end
   end

   assign s_out = (raw_ff > 21'(W_ONE)) ? W_ONE : raw_ff[16:0];

endmodule

>>> rtl/pgu_blend.sv
// Two-stage bilinear blend of four ARGB colors, horizontal then vertical; c00 passes through when smooth is low.
module pgu_blend (
   input  logic        clock,
   input  logic        en,
   input  logic        smooth,
   input  logic [31:0] c00,
   input  logic [31:0] c01,
   input  logic [31:0] c10,
   input  logic [31:0] c11,
   input  logic [16:0] sx,
   input  logic [16:0] sy,
   output logic [31:0] color
);
   logic [16:0] sy_ff;
   logic [31:0] near_ff;
   logic [31:0] blend_in;
   logic [31:0] color_ff;

   for (genvar k = 0; k < 4; k++) begin : g_chan
      logic [7:0]         a, b, c, d;
      logic signed [8:0]  dtop, dbot;
      logic signed [26:0] ptop, pbot;
      logic [26:0]        top_sum, bot_sum;
      logic [23:0]        top_ff, bot_ff;
      logic signed [24:0] dv;
      logic signed [42:0] pv;
      logic [42:0]        v_sum;

      assign a = c00[8*k +: 8];
      assign b = c01[8*k +: 8];
      assign c = c10[8*k +: 8];
      assign d = c11[8*k +: 8];

      // row = a*(W-sx) + b*sx = a*W + (b-a)*sx
      assign dtop    = $signed({1'b0, b}) - $signed({1'b0, a});
      assign dbot    = $signed({1'b0, d}) - $signed({1'b0, c});
      assign ptop    = dtop * $signed({1'b0, sx});
      assign pbot    = dbot * $signed({1'b0, sx});
      assign top_sum = {3'b0, a, 16'b0} + 27'(ptop);
      assign bot_sum = {3'b0, c, 16'b0} + 27'(pbot);

      always_ff @(posedge clock) begin
         if (en) begin
            top_ff <= top_sum[23:0];
            bot_ff <= bot_sum[23:0];
         end
      end

      assign dv    = $signed({1'b0, bot_ff}) - $signed({1'b0, top_ff});
      assign pv    = dv * $signed({1'b0, sy_ff});
      assign v_sum = {3'b0, top_ff, 16'b0} + 43'(pv);
      assign blend_in[8*k +: 8] = v_sum[39:32];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sy_ff    <= sy;
         near_ff  <= c00;
         color_ff <= smooth ? blend_in : near_ff;
      end
   end

   assign color = color_ff;

endmodule

>>> rtl/palette_grid_upscaler_unit.sv
// A render transfer on req is registered through stages s1 to s8 and gives its result on rsp.
// Throughput: one item per cycle; a stall on rsp holds all eight stages.
// Write items update the grid in stage 3 when their cell lies in the grid, and leave no result.
// Reset: synchronous; a clearing pass then zeroes the grid, one word per bank a cycle, through
// all ((GRID_DIM+1)/2)^2 words of each bank (1024 at GRID_DIM 64), with req_tready low.
`include "palette_grid_upscaler_unit_assert.svh"
module palette_grid_upscaler_unit #(
   parameter int GRID_DIM    = 64,
   parameter int OWNER_COUNT = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // cell_x, cell_y, owner, pix_x, pix_y
   input  logic [pgu_pkg::REQ_DATA_W-1:0]     req_tdata,
   // op
   input  logic [0:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_x, out_y, color
   output logic [pgu_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // write_pixel
   output logic [0:0]                         rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pgu_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pgu_pkg::CSR_DATA_W-1:0]     csr_data
);
   import pgu_pkg::*;

   localparam int CW = $clog2(GRID_DIM);
   localparam logic [20:0] LAST_C = 21'(GRID_DIM - 1);
   localparam logic [CW-1:0] LAST = CW'(GRID_DIM - 1);
   localparam logic [CW-1:0] PEN  = CW'(GRID_DIM - 2);
   localparam logic [3:0] OWN_CNT = 4'(OWNER_COUNT);

   // configuration
   logic        smooth_mode_ff, overlay_mode_ff;
   logic [23:0] x_step_ff, y_step_ff;
   logic [31:0] background_color_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_mode_ff      <= 1'b0;
         overlay_mode_ff     <= 1'b0;
         x_step_ff           <= 24'h010000;
         y_step_ff           <= 24'h010000;
         background_color_ff <= 32'h0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_SMOOTH:  smooth_mode_ff      <= csr_data[0];
            CSR_OVERLAY: overlay_mode_ff     <= csr_data[0];
            CSR_X_STEP:  x_step_ff           <= csr_data[23:0];
            CSR_Y_STEP:  y_step_ff           <= csr_data[23:0];
            CSR_BG:      background_color_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // input fields
   logic [5:0]  req_cell_x, req_cell_y;
   logic [3:0]  req_owner;
   logic [11:0] req_pix_x, req_pix_y;

   assign req_cell_x = req_tdata[5:0];
   assign req_cell_y = req_tdata[11:6];
   assign req_owner  = req_tdata[15:12];
   assign req_pix_x  = req_tdata[27:16];
   assign req_pix_y  = req_tdata[39:28];

   // stage registers
   logic          s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic          s5_valid_ff, s6_valid_ff, s7_valid_ff, s8_valid_ff;
   logic          s1_render_ff, s2_render_ff, s3_render_ff;
   logic          s1_wok_ff, s2_wok_ff, s3_wok_ff;
   logic [CW-1:0] s1_wx_ff, s2_wx_ff, s3_wx_ff;
   logic [CW-1:0] s1_wy_ff, s2_wy_ff, s3_wy_ff;
   logic [3:0]    s1_own_ff, s2_own_ff, s3_own_ff;
   logic [23:0]   s1_pix_ff, s2_pix_ff, s3_pix_ff, s4_pix_ff;
   logic [23:0]   s5_pix_ff, s6_pix_ff, s7_pix_ff, s8_pix_ff;
   logic [36:0]   s2_px_ff, s2_py_ff, s2_px_in, s2_py_in;
   logic [CW-1:0] s3_cx_ff, s3_cy_ff;
   logic [16:0]   s3_tx_ff, s3_ty_ff;
   logic [CW+16:0] s3_mx_in, s3_my_in;
   logic [31:0]   s5_c00_ff, s5_c01_ff, s5_c10_ff, s5_c11_ff;
   logic [31:0]   s6_c00_ff, s6_c01_ff, s6_c10_ff, s6_c11_ff;
   logic [3:0]    g00, g01, g10, g11;
   logic [16:0]   sx, sy;
   logic [31:0]   color;
   logic          wok_in;
   logic          any_valid;

   logic adv, grid_busy, accept;

   assign adv        = !s8_valid_ff || rsp_tready;
   assign req_tready = adv && !grid_busy;
   assign accept     = req_tvalid && req_tready;

   assign any_valid = s1_valid_ff || s2_valid_ff || s3_valid_ff || s4_valid_ff ||
                      s5_valid_ff || s6_valid_ff || s7_valid_ff || s8_valid_ff;

   // map a Q.16 position to {cell, weight of the next cell}
   function automatic logic [CW+16:0] map_pos(input logic [36:0] p, input logic smooth);
      logic [20:0]   c;
      logic [CW-1:0] cell_idx;
      logic [16:0]   t;
      c        = p[36:16];
      cell_idx = CW'(c);
      t        = {1'b0, p[15:0]};
      if (smooth) begin
         if (c >= LAST_C) begin
            cell_idx = PEN;
            t        = W_ONE;
         end
      end else begin
         t = '0;
         if (c > LAST_C) begin
            cell_idx = LAST;
         end
      end
      return {cell_idx, t};
   endfunction

   assign wok_in   = (32'(req_cell_x) < 32'(GRID_DIM)) && (32'(req_cell_y) < 32'(GRID_DIM));
   assign s2_px_in = P_HALF + 37'(s1_pix_ff[11:0]) * 37'(x_step_ff);
   assign s2_py_in = P_HALF + 37'(s1_pix_ff[23:12]) * 37'(y_step_ff);
   assign s3_mx_in = map_pos(s2_px_ff, smooth_mode_ff);
   assign s3_my_in = map_pos(s2_py_ff, smooth_mode_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         // drop write items once the grid has taken them
         s4_valid_ff <= s3_valid_ff && s3_render_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
         s8_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_render_ff <= (op_type'(req_tuser[0]) == OP_RENDER);
         s1_wok_ff    <= wok_in;
         s1_wx_ff     <= CW'(req_cell_x);
         s1_wy_ff     <= CW'(req_cell_y);
         s1_own_ff    <= req_owner;
         s1_pix_ff    <= {req_pix_y, req_pix_x};

         s2_render_ff <= s1_render_ff;
         s2_wok_ff    <= s1_wok_ff;
         s2_wx_ff     <= s1_wx_ff;
         s2_wy_ff     <= s1_wy_ff;
         s2_own_ff    <= s1_own_ff;
         s2_pix_ff    <= s1_pix_ff;
         s2_px_ff     <= s2_px_in;
         s2_py_ff     <= s2_py_in;

         s3_render_ff <= s2_render_ff;
         s3_wok_ff    <= s2_wok_ff;
         s3_wx_ff     <= s2_wx_ff;
         s3_wy_ff     <= s2_wy_ff;
         s3_own_ff    <= s2_own_ff;
         s3_pix_ff    <= s2_pix_ff;
         s3_cx_ff     <= s3_mx_in[CW+16:17];
         s3_tx_ff     <= s3_mx_in[16:0];
         s3_cy_ff     <= s3_my_in[CW+16:17];
         s3_ty_ff     <= s3_my_in[16:0];

         s4_pix_ff    <= s3_pix_ff;

         s5_pix_ff    <= s4_pix_ff;
         s5_c00_ff    <= palette_color(g00, background_color_ff, OWN_CNT);
         s5_c01_ff    <= palette_color(g01, background_color_ff, OWN_CNT);
         s5_c10_ff    <= palette_color(g10, background_color_ff, OWN_CNT);
         s5_c11_ff    <= palette_color(g11, background_color_ff, OWN_CNT);

         s6_pix_ff    <= s5_pix_ff;
         s6_c00_ff    <= s5_c00_ff;
         s6_c01_ff    <= s5_c01_ff;
         s6_c10_ff    <= s5_c10_ff;
         s6_c11_ff    <= s5_c11_ff;

         s7_pix_ff    <= s6_pix_ff;
         s8_pix_ff    <= s7_pix_ff;
      end
   end

   pgu_grid_ram #(.GRID_DIM(GRID_DIM)) u_grid (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .rd_x     (s3_cx_ff),
      .rd_y     (s3_cy_ff),
      .wr_en    (adv && s3_valid_ff && !s3_render_ff && s3_wok_ff),
      .wr_x     (s3_wx_ff),
      .wr_y     (s3_wy_ff),
      .wr_owner (s3_own_ff),
      .busy     (grid_busy),
      .q00      (g00),
      .q01      (g01),
      .q10      (g10),
      .q11      (g11)
   );

   pgu_smoother u_smooth_x (
      .clock (clock),
      .en    (adv),
      .t_in  (s3_tx_ff),
      .s_out (sx)
   );

   pgu_smoother u_smooth_y (
      .clock (clock),
      .en    (adv),
      .t_in  (s3_ty_ff),
      .s_out (sy)
   );

   pgu_blend u_blend (
      .clock  (clock),
      .en     (adv),
      .smooth (smooth_mode_ff),
      .c00    (s6_c00_ff),
      .c01    (s6_c01_ff),
      .c10    (s6_c10_ff),
      .c11    (s6_c11_ff),
      .sx     (sx),
      .sy     (sy),
      .color  (color)
   );

   assign rsp_tvalid   = s8_valid_ff;
   assign rsp_tdata    = {color, s8_pix_ff};
   assign rsp_tuser[0] = !(overlay_mode_ff && (color[31:24] != ALPHA_OPAQUE));

   `PGU_ASSERT_SAME(a_clear_pipe_empty, grid_busy, !any_valid)
   `PGU_ASSERT_NEXT(a_clear_stays_done, !grid_busy, !grid_busy)
   `PGU_ASSERT_NEXT(a_write_no_result, adv && s3_valid_ff && !s3_render_ff, !s4_valid_ff)

endmodule
